[rtl/core/dtr_pkg.sv]
package dtr_pkg;

  localparam int CYCLE_WIDTH = 10;

  localparam int PS_W   = 10;
  localparam int PC_W   = ((CYCLE_WIDTH > PS_W) ? CYCLE_WIDTH : PS_W) + 1;
  localparam int TICK_W = PC_W - 4;
  // ticks plus the 8-bit counter, one carry bit on top
  localparam int SUM_W  = ((TICK_W > 8) ? TICK_W : 8) + 1;
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [PC_W-1:0] CYC_MASK = PC_W'((64'd1 << CYCLE_WIDTH) - 64'd1);

  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam logic [1:0] RATE_1024 = 2'd0;
  localparam logic [1:0] RATE_16   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_256  = 2'd3;

  typedef struct packed {
    logic load_in;
    logic adv;
    logic mod_step;
    logic mod_fin;
    logic access;
    logic load_out;
  } dtr_cmd_t;

  typedef struct packed {
    logic need_mod;
  } dtr_status_t;

  function automatic logic [TICK_W-1:0] rate_ticks(logic [PC_W-1:0] pc, logic [1:0] sel);
    logic [TICK_W-1:0] t;
    unique case (sel)
      RATE_1024: t = TICK_W'(pc >> 10);
      RATE_16:   t = TICK_W'(pc >> 4);
      RATE_64:   t = TICK_W'(pc >> 6);
      RATE_256:  t = TICK_W'(pc >> 8);
      default:   t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [PS_W-1:0] rate_left(logic [PC_W-1:0] pc, logic [1:0] sel);
    logic [PS_W-1:0] r;
    unique case (sel)
      RATE_1024: r = pc[9:0];
      RATE_16:   r = {6'd0, pc[3:0]};
      RATE_64:   r = {4'd0, pc[5:0]};
      RATE_256:  r = {2'd0, pc[7:0]};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic glitch_hit(logic [PS_W-1:0] ps, logic [1:0] sel);
    logic g;
    unique case (sel)
      RATE_1024: g = ps[9];
      RATE_16:   g = ps[3];
      RATE_64:   g = ps[5];
      RATE_256:  g = ps[7];
      default:   g = 1'b0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/dtr_if.sv]
interface dtr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [9:0]  cycles;

  modport source (output valid, output action, output address, output write_data,
                  output cycles, input ready);
  modport sink (input valid, input action, input address, input write_data,
                input cycles, output ready);
endinterface

interface dtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       timer_irq;

  modport source (output valid, output read_data, output timer_irq, input ready);
  modport sink (input valid, input read_data, input timer_irq, output ready);
endinterface

[rtl/core/dtr_datapath.sv]
module dtr_datapath
  import dtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dtr_cmd_t    cmd,
  output dtr_status_t status,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [9:0]  in_cycles,
  output logic [7:0]  out_read_data,
  output logic        out_timer_irq
);

  // latched request
  logic [1:0]       act_r;
  logic [15:0]      addr_r;
  logic [7:0]       wdata_r;
  logic [PC_W-1:0]  cyc_r;

  // timer state
  logic [7:0]       div_r, div_nxt;
  logic [7:0]       sub_r, sub_nxt;
  logic [PS_W-1:0]  ps_r, ps_nxt;
  logic [7:0]       tc_r, tc_nxt;
  logic [7:0]       mod_r, mod_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             on_r, on_nxt;
  logic             ovf_r, ovf_nxt;
  logic             rld_r, rld_nxt;
  logic             irq_r, irq_nxt;
  logic [7:0]       rd_r, rd_nxt;

  // remainder unit
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [7:0]       p_r, p_nxt;
  logic [8:0]       d_r, d_nxt;

  logic [7:0]       out_rd_r;
  logic             out_irq_r;

  // advance terms
  logic             do_adv;
  logic [PC_W-1:0]  div_sum;
  logic [PC_W-1:0]  pc;
  logic [PS_W-1:0]  ps_left;
  logic [SUM_W-1:0] tsum;
  logic             wrap;
  logic [SUM_W-1:0] rem;
  logic [8:0]       divisor;
  logic             rem_big;
  logic [8:0]       trial;
  logic             gl;

  assign do_adv  = !(act_r == ACT_READ || act_r == ACT_WRITE) || (cyc_r != '0);
  assign div_sum = PC_W'(sub_r) + cyc_r;
  assign pc      = PC_W'(ps_r) + cyc_r;
  assign ps_left = rate_left(pc, sel_r);
  assign tsum    = SUM_W'(rate_ticks(pc, sel_r)) + SUM_W'(tc_r);
  assign wrap    = tsum > SUM_W'(255);
  assign rem     = tsum - SUM_W'(256);
  assign divisor = 9'h100 - {1'b0, mod_r};
  assign rem_big = rem >= SUM_W'(divisor);
  assign trial   = {p_r, q_r[SUM_W-1]};
  assign gl      = on_r && glitch_hit(ps_r, sel_r);

  assign status.need_mod = do_adv && on_r && wrap && rem_big;

  always_comb begin
    div_nxt = div_r;
    sub_nxt = sub_r;
    ps_nxt  = ps_r;
    tc_nxt  = tc_r;
    mod_nxt = mod_r;
    sel_nxt = sel_r;
    on_nxt  = on_r;
    ovf_nxt = ovf_r;
    rld_nxt = rld_r;
    irq_nxt = irq_r;
    rd_nxt  = rd_r;
    q_nxt   = q_r;
    p_nxt   = p_r;
    d_nxt   = d_r;

    if (cmd.load_in) begin
      irq_nxt = 1'b0;
      rd_nxt  = 8'd0;
    end

    if (cmd.adv && do_adv) begin
      div_nxt = div_r + 8'(div_sum >> 8);
      sub_nxt = div_sum[7:0];
      rld_nxt = ovf_r && (cyc_r == PC_W'(4));
      ovf_nxt = 1'b0;
      if (on_r) begin
        ps_nxt = ps_left;
        if (wrap) begin
          irq_nxt = 1'b1;
          // exact overflow opens the short windows
          if (tsum == SUM_W'(256)) begin
            if (ps_left < PS_W'(4)) begin
              ovf_nxt = 1'b1;
            end else if (ps_left < PS_W'(8)) begin
              rld_nxt = 1'b1;
            end
          end
          if (rem_big) begin
            q_nxt = rem;
            p_nxt = 8'd0;
            d_nxt = divisor;
          end else begin
            tc_nxt = mod_r + rem[7:0];
          end
        end else begin
          tc_nxt = tsum[7:0];
        end
      end
    end

    // one remainder bit per step
    if (cmd.mod_step) begin
      q_nxt = q_r << 1;
      if (trial >= d_r) begin
        p_nxt = 8'(trial - d_r);
      end else begin
        p_nxt = trial[7:0];
      end
    end

    if (cmd.mod_fin) begin
      tc_nxt = mod_r + p_r;
    end

    if (cmd.access) begin
      if (act_r == ACT_READ) begin
        unique case (addr_r)
          ADDR_DIV:  rd_nxt = div_r;
          ADDR_TIMA: rd_nxt = ovf_r ? 8'd0 : tc_r;
          ADDR_TMA:  rd_nxt = mod_r;
          ADDR_TAC:  rd_nxt = {5'd0, on_r, sel_r};
          default:   rd_nxt = 8'hFF;
        endcase
      end else if (act_r == ACT_WRITE) begin
        unique case (addr_r)
          ADDR_DIV: begin
            if (gl) begin
              if (tc_r == 8'hFF) begin
                irq_nxt = 1'b1;
                tc_nxt  = mod_r;
              end else begin
                tc_nxt = tc_r + 8'd1;
              end
            end
            div_nxt = 8'd0;
            sub_nxt = 8'd0;
            ps_nxt  = '0;
          end
          ADDR_TIMA: begin
            if (!rld_r) begin
              tc_nxt = wdata_r;
            end
          end
          ADDR_TMA: begin
            mod_nxt = wdata_r;
            if (ovf_r || rld_r) begin
              tc_nxt = wdata_r;
            end
          end
          ADDR_TAC: begin
            // turning the timer off can tick the counter once
            if (gl && !wdata_r[2]) begin
              if (tc_r == 8'hFF) begin
                irq_nxt = 1'b1;
                tc_nxt  = mod_r;
              end else begin
                tc_nxt = tc_r + 8'd1;
              end
            end
            sel_nxt = wdata_r[1:0];
            on_nxt  = wdata_r[2];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
      sub_r <= '0;
      ps_r  <= '0;
      tc_r  <= '0;
      mod_r <= '0;
      sel_r <= '0;
      on_r  <= 1'b0;
      ovf_r <= 1'b0;
      rld_r <= 1'b0;
      irq_r <= 1'b0;
    end else begin
      div_r <= div_nxt;
      sub_r <= sub_nxt;
      ps_r  <= ps_nxt;
      tc_r  <= tc_nxt;
      mod_r <= mod_nxt;
      sel_r <= sel_nxt;
      on_r  <= on_nxt;
      ovf_r <= ovf_nxt;
      rld_r <= rld_nxt;
      irq_r <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r   <= in_action;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      cyc_r   <= PC_W'(in_cycles) & CYC_MASK;
    end
    if (cmd.load_out) begin
      out_rd_r  <= rd_r;
      out_irq_r <= irq_r;
    end
    rd_r <= rd_nxt;
    q_r  <= q_nxt;
    p_r  <= p_nxt;
    d_r  <= d_nxt;
  end

  assign out_read_data = out_rd_r;
  assign out_timer_irq = out_irq_r;

endmodule

[rtl/core/dtr_ctrl.sv]
module dtr_ctrl
  import dtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dtr_status_t status,
  output dtr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_MOD,
    S_FIN,
    S_ACC,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] step_r;
  logic             out_valid_r;
  logic             step_last;
  logic             out_free;

  assign step_last = step_r == CNT_W'(SUM_W - 1);
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state_r == S_IDLE) && in_valid;
    cmd.adv      = state_r == S_ADV;
    cmd.mod_step = state_r == S_MOD;
    cmd.mod_fin  = state_r == S_FIN;
    cmd.access   = state_r == S_ACC;
    cmd.load_out = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads, otherwise a waiting one stays until taken
      out_valid_r <= ((state_r == S_DONE) && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          step_r  <= '0;
          state_r <= status.need_mod ? S_MOD : S_ACC;
        end
        S_MOD: begin
          step_r <= step_r + CNT_W'(1);
          if (step_last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ADV))
    else $error("accepted request did not start the advance step");

  a_mod_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && step_last) |=> (state_r == S_FIN))
    else $error("remainder unit ran past its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result left before the pending one was taken");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

endmodule

[rtl/core/divider_timer_with_reload.sv]
// channel  dir  handshake            payload
// in_ch    in   valid/ready          action, address, write_data, cycles
// out_ch   out  valid/ready          read_data, timer_irq
//
// a request steps through accept, advance, register access and result load
// a counter wrap that spans more than one modulo period adds the remainder steps
// and a finish step for the bit-serial remainder unit
// rst_n is synchronous and active low; all timer registers clear to zero
// the next request is accepted while a finished result waits on out_ch;
// a stalled out_ch holds the following result in the done step
module divider_timer_with_reload
  import dtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtr_in_if.sink    in_ch,
  dtr_out_if.source out_ch
);

  dtr_cmd_t    cmd;
  dtr_status_t status;

  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_action     (in_ch.action),
    .in_address    (in_ch.address),
    .in_write_data (in_ch.write_data),
    .in_cycles     (in_ch.cycles),
    .out_read_data (out_ch.read_data),
    .out_timer_irq (out_ch.timer_irq)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dtr_pkg::*;

  localparam logic [1:0] ACT_IDLE  = 2'd0;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 150;
  localparam int LATE_HOLD_AT   = 1100;
  localparam int PAUSE_AT       = 700;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [9:0]  cyc;
    logic        fixed;
    logic [7:0]  fixed_rd;
    logic        fixed_irq;
  } request_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } result_t;

  logic clk;
  logic rst_n;

  dtr_in_if  in_ch ();
  dtr_out_if out_ch ();

  divider_timer_with_reload dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the timer registers
  logic [7:0] shadow_div      = '0;
  logic [7:0] shadow_div_sub  = '0;
  logic [9:0] shadow_prescale = '0;
  logic [7:0] shadow_tima     = '0;
  logic [7:0] shadow_tma      = '0;
  logic [1:0] shadow_rate     = '0;
  logic       shadow_on       = 1'b0;
  logic       shadow_ovf      = 1'b0;
  logic       shadow_reload   = 1'b0;
  logic       tick_irq        = 1'b0;

  result_t  pending_results [$];
  request_t stim_q [$];
  request_t offered;

  int  send_idle_pct = 25;
  int  recv_idle_pct = 58;
  bit  hold_request  = 1'b0;
  int  errors        = 0;
  int  quiet_cycles  = 0;
  int  req_count     = 0;
  int  read_count    = 0;
  int  write_count   = 0;
  int  irq_count     = 0;
  int  window_hits   = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned rate_shift(logic [1:0] rate);
    case (rate)
      RATE_1024: return 10;
      RATE_16:   return 4;
      RATE_64:   return 6;
      default:   return 8;
    endcase
  endfunction

  // extra counter tick when the selected prescaler bit falls
  function automatic void glitch_check();
    if (shadow_prescale[rate_shift(shadow_rate) - 1]) begin
      if (shadow_tima == 8'hFF) begin
        tick_irq    = 1'b1;
        shadow_tima = shadow_tma;
      end else begin
        shadow_tima = shadow_tima + 8'd1;
      end
    end
  endfunction

  function automatic result_t predict_access(logic [1:0] act, logic [15:0] addr,
                                             logic [7:0] wdata, logic [9:0] cyc);
    result_t     res;
    int unsigned sum;
    int unsigned pc;
    int unsigned ticks;
    int unsigned shift;
    res      = '0;
    tick_irq = 1'b0;
    if (act == ACT_IDLE || act == ACT_SPARE || cyc != 0) begin
      sum            = shadow_div_sub + cyc;
      shadow_div     = 8'(shadow_div + (sum >> 8));
      shadow_div_sub = 8'(sum);
      shadow_reload  = shadow_ovf && (cyc == 10'd4);
      shadow_ovf     = 1'b0;
      if (shadow_on) begin
        shift           = rate_shift(shadow_rate);
        pc              = shadow_prescale + cyc;
        ticks           = pc >> shift;
        shadow_prescale = 10'(pc & ((32'd1 << shift) - 1));
        if (ticks + shadow_tima > 32'd255) begin
          // exact wrap opens the overflow or the reload window
          if (ticks + shadow_tima == 32'd256) begin
            if (shadow_prescale < 10'd4) shadow_ovf = 1'b1;
            else if (shadow_prescale < 10'd8) shadow_reload = 1'b1;
            if (shadow_ovf || shadow_reload) window_hits++;
          end
          tick_irq    = 1'b1;
          ticks       = ticks - (32'd256 - shadow_tima);
          shadow_tima = 8'(shadow_tma + ticks % (32'd256 - shadow_tma));
        end else begin
          shadow_tima = 8'(shadow_tima + ticks);
        end
      end
    end
    if (act == ACT_READ) begin
      case (addr)
        ADDR_DIV:  res.rd = shadow_div;
        ADDR_TIMA: res.rd = shadow_ovf ? 8'h00 : shadow_tima;
        ADDR_TMA:  res.rd = shadow_tma;
        ADDR_TAC:  res.rd = {5'd0, shadow_on, shadow_rate};
        default:   res.rd = 8'hFF;
      endcase
    end else if (act == ACT_WRITE) begin
      case (addr)
        ADDR_DIV: begin
          if (shadow_on) glitch_check();
          shadow_div      = '0;
          shadow_div_sub  = '0;
          shadow_prescale = '0;
        end
        ADDR_TIMA: begin
          if (!shadow_reload) shadow_tima = wdata;
        end
        ADDR_TMA: begin
          shadow_tma = wdata;
          if (shadow_ovf || shadow_reload) shadow_tima = shadow_tma;
        end
        ADDR_TAC: begin
          if (shadow_on && !wdata[2]) glitch_check();
          shadow_rate = wdata[1:0];
          shadow_on   = wdata[2];
        end
        default: ;
      endcase
    end
    res.irq = tick_irq;
    return res;
  endfunction

  function automatic request_t mk_request(logic [1:0] act, logic [15:0] addr,
                                          logic [7:0] wdata, logic [9:0] cyc,
                                          logic fixed = 1'b0, logic [7:0] rd = 8'h00,
                                          logic irq = 1'b0);
    request_t r;
    r.act       = act;
    r.addr      = addr;
    r.wdata     = wdata;
    r.cyc       = cyc;
    r.fixed     = fixed;
    r.fixed_rd  = rd;
    r.fixed_irq = irq;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic drive_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    offered = r;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= r.act;
    in_ch.address    <= r.addr;
    in_ch.write_data <= r.wdata;
    in_ch.cycles     <= r.cyc;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // receiver side: random stalls plus the occasional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t predicted;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predicted = predict_access(in_ch.action, in_ch.address, in_ch.write_data,
                                 in_ch.cycles);
      if (offered.fixed) predicted = {offered.fixed_rd, offered.fixed_irq};
      pending_results.push_back(predicted);
      req_count++;
      if (in_ch.action == ACT_READ) read_count++;
      if (in_ch.action == ACT_WRITE) write_count++;
      if (predicted.irq) irq_count++;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result rd=%02h irq=%0b with no request pending",
                                  out_ch.read_data, out_ch.timer_irq));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_data !== want.rd)
          report_mismatch($sformatf("read_data %02h, expected %02h",
                                    out_ch.read_data, want.rd));
        if (out_ch.timer_irq !== want.irq)
          report_mismatch($sformatf("timer_irq %0b, expected %0b",
                                    out_ch.timer_irq, want.irq));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    request_t    r;
    request_t    directed_rows [$];
    logic [1:0]  rate;
    logic [7:0]  w;
    int unsigned period;
    int unsigned extra;
    int          sent;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_IDLE;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    in_ch.cycles     = '0;
    offered          = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers right after reset, unmapped addresses, divider advance with the timer off, then enabling it
    directed_rows.push_back(mk_request(ACT_READ, ADDR_DIV, 8'h00, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TMA, 8'h00, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TAC, 8'h00, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_READ, 16'h0000, 8'h00, 0, 1'b1, 8'hFF));
    directed_rows.push_back(mk_request(ACT_READ, 16'hFFFF, 8'h00, 0, 1'b1, 8'hFF));
    directed_rows.push_back(mk_request(ACT_WRITE, 16'hFF08, 8'hFF, 0, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 1023, 1'b1, 8'h00));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_DIV, 8'h00, 0, 1'b1, 8'h03));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TMA, 8'hFE, 0));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TAC, 8'hFD, 0));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TAC, 8'h00, 0, 1'b1, 8'h05));
    // exact wrap, then the overflow and reload windows
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TIMA, 8'hFF, 0));
    directed_rows.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 16));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00, 0));
    directed_rows.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 4));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TIMA, 8'h12, 0));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TMA, 8'hF0, 0));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00, 0));
    // glitch ticks on divider reset and on disable
    directed_rows.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 4));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_DIV, 8'h00, 0));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TIMA, 8'hFF, 0));
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TAC, 8'h00, 8));
    // long step wraps through several modulo periods
    directed_rows.push_back(mk_request(ACT_WRITE, ADDR_TAC, 8'h05, 0));
    directed_rows.push_back(mk_request(ACT_SPARE, 16'h0000, 8'h00, 1023));
    directed_rows.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00, 0));

    foreach (directed_rows[i]) drive_request(directed_rows[i]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (stim_q.size() == 0) begin
        if ($urandom_range(99) < 35) begin
          // well-formed wrap: arm counter at the top, land near the rate edge
          rate   = 2'($urandom_range(3));
          period = (rate == RATE_1024) ? 1024 : (32'd1 << rate_shift(rate));
          extra  = $urandom_range(7);
          w      = 8'($urandom);
          w[2]   = 1'b1;
          w[1:0] = rate;
          stim_q.push_back(mk_request(ACT_WRITE, ADDR_TAC, w, 0));
          stim_q.push_back(mk_request(ACT_WRITE, ADDR_DIV, 8'($urandom), 0));
          stim_q.push_back(mk_request(ACT_WRITE, ADDR_TIMA,
                                      ($urandom_range(3) == 0) ? 8'hFE : 8'hFF, 0));
          if (rate == RATE_1024) begin
            stim_q.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 512));
            stim_q.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 10'(512 + extra)));
          end else begin
            stim_q.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 10'(period + extra)));
          end
          case ($urandom_range(3))
            0: stim_q.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00,
                                           10'(4 * $urandom_range(2))));
            1: stim_q.push_back(mk_request(ACT_WRITE, ADDR_TIMA, 8'($urandom),
                                           10'(4 * $urandom_range(2))));
            2: stim_q.push_back(mk_request(ACT_WRITE, ADDR_TMA, 8'($urandom),
                                           10'(4 * $urandom_range(2))));
            default: stim_q.push_back(mk_request(ACT_IDLE, 16'h0000, 8'h00, 4));
          endcase
          stim_q.push_back(mk_request(ACT_READ, ADDR_TIMA, 8'h00, 0));
        end else begin
          case ($urandom_range(9))
            0, 1, 2: r.act = ACT_IDLE;
            3:       r.act = ACT_SPARE;
            4, 5, 6: r.act = ACT_READ;
            default: r.act = ACT_WRITE;
          endcase
          r.addr  = ($urandom_range(7) == 0) ? 16'($urandom)
                                             : 16'(ADDR_DIV + $urandom_range(3));
          r.wdata = 8'($urandom);
          if (r.addr == ADDR_TAC && $urandom_range(4) != 0) r.wdata[2] = 1'b1;
          if (r.addr == ADDR_TIMA && $urandom_range(1) == 1) r.wdata[7:4] = 4'hF;
          case ($urandom_range(7))
            0:       r.cyc = 10'd0;
            1:       r.cyc = 10'd4;
            2:       r.cyc = 10'($urandom_range(8));
            3:       r.cyc = 10'(16 * $urandom_range(1, 8) + $urandom_range(7));
            4, 5:    r.cyc = 10'($urandom_range(1023));
            6:       r.cyc = 10'd1023;
            default: r.cyc = 10'(256 * $urandom_range(1, 3) + $urandom_range(7));
          endcase
          r.fixed     = 1'b0;
          r.fixed_rd  = 8'h00;
          r.fixed_irq = 1'b0;
          stim_q.push_back(r);
        end
      end

      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 58;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (sent == HOLD_AT || sent == LATE_HOLD_AT) hold_request = 1'b1;
      if (sent == PAUSE_AT) begin
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end

      drive_request(stim_q.pop_front());
      sent++;
    end

    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("run: %0d requests (%0d reads, %0d writes), %0d timer interrupts expected",
             req_count, read_count, write_count, irq_count);
    $display("exact wraps landing in the overflow or reload window: %0d, mismatches: %0d",
             window_hits, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
